### sv/lfo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFO package
// Shared types, register indexes and the quarter-wave sine table functions
// for the multi-waveform low-frequency oscillator.
// ----------------------------------------------------------------------------
package lfo_pkg;

   localparam int LFO_PHASE_BITS  = 32;
   localparam int LFO_OUT_BITS    = 16;
   localparam int LFO_SINE_DEPTH  = 256;
   localparam int LFO_SINE_LOG    = $clog2(LFO_SINE_DEPTH);
   localparam int LFO_CSR_DATA_W  = 32;
   localparam int LFO_CSR_INDEX_W = 2;
   localparam int LFO_PROD_W      = 48;

   localparam logic [63:0] LFO_Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] LFO_HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [31:0] LFO_Q30_POS = 32'sh4000_0000;
   localparam logic signed [31:0] LFO_Q30_NEG = -32'sh4000_0000;

   typedef enum logic [LFO_CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_PHASE_OFFSET = 2'd1,
      CSR_WAVE_SELECT  = 2'd2,
      CSR_GAIN         = 2'd3
   } lfo_csr_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAWTOOTH = 2'd3
   } lfo_wave_type;

   // Sine of a Q30 angle in [0, pi/2] by a truncating nested Taylor series.
   function automatic logic [63:0] lfo_sine_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] term;
      x2   = (x * x) >> 30;
      t    = LFO_Q30_ONE;
      term = ((x2 * t) >> 30) / 64'd156;
      t    = (term >= LFO_Q30_ONE) ? 64'd0 : LFO_Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd110;
      t    = (term >= LFO_Q30_ONE) ? 64'd0 : LFO_Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd72;
      t    = (term >= LFO_Q30_ONE) ? 64'd0 : LFO_Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd42;
      t    = (term >= LFO_Q30_ONE) ? 64'd0 : LFO_Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd20;
      t    = (term >= LFO_Q30_ONE) ? 64'd0 : LFO_Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd6;
      t    = (term >= LFO_Q30_ONE) ? 64'd0 : LFO_Q30_ONE - term;
      return (x * t) >> 30;
   endfunction

   // Table entry i of the quarter wave, clamped to +1.0.
   function automatic logic [30:0] lfo_sine_entry(input int i);
      logic [63:0] x;
      logic [63:0] s;
      x = (LFO_HALF_PI_Q30 * 64'(i)) / LFO_SINE_DEPTH;
      s = lfo_sine_q30(x);
      return 31'((s > LFO_Q30_ONE) ? LFO_Q30_ONE : s);
   endfunction

   // Rising slope from entry i to entry i+1, never negative.
   function automatic logic [30:0] lfo_sine_delta(input int i);
      logic [30:0] a;
      logic [30:0] b;
      a = lfo_sine_entry(i);
      b = lfo_sine_entry(i + 1);
      return (b >= a) ? (b - a) : 31'd0;
   endfunction

endpackage

### sv/lfo_multi_waveform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-waveform LFO core
// Phase accumulator oscillator giving sine, square, triangle or sawtooth
// samples in signed fixed point, scaled by a programmable gain.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the req channel is one tick. The block outputs the sample at
// the current phase (accumulator plus offset) and, when req_advance is set,
// then adds the phase step to the accumulator.
// Each accepted word yields exactly one word on the rsp channel, in order.
// The datapath is a five-register pipeline (phase, table lookup,
// interpolation, gain multiply, rounding); a tick passes through these
// registers in that order before rsp_valid rises. One tick is taken every
// cycle while req_ready is high.
// The phase accumulator update is a single add, which is what allows a new
// tick in every cycle.
// When the receiver stalls, words collect in the pipeline stages; req_ready
// only drops once every stage holds a word.
// Synchronous reset clears the phase, empties the pipeline and restores the
// registers: phase step 0, offset 0, sine, gain 65535. Registers are to be
// written through the csr port while no tick is in flight; the user, not the core, sees to it.
// ----------------------------------------------------------------------------
module lfo_multi_waveform_core
   import lfo_pkg::*;
#(
   parameter int PHASE_BITS = LFO_PHASE_BITS,
   parameter int OUT_BITS   = LFO_OUT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_advance,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_sample,
   input  logic                       csr_we,
   input  logic [LFO_CSR_INDEX_W-1:0] csr_index,
   input  logic [LFO_CSR_DATA_W-1:0]  csr_wdata
);

   localparam int UP_SHIFT   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int DOWN_SHIFT = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
   localparam int RND_SHIFT  = 47 - OUT_BITS;
   localparam int FRAC_LOW   = 30 - LFO_SINE_LOG;

   localparam logic signed [LFO_PROD_W-1:0] ROUND_BIAS =
      48'sd1 <<< (RND_SHIFT - 1);
   localparam logic signed [LFO_PROD_W-1:0] SAT_MAX =
      (48'sd1 <<< (OUT_BITS - 1)) - 48'sd1;
   localparam logic signed [LFO_PROD_W-1:0] SAT_MIN =
      -(48'sd1 <<< (OUT_BITS - 1));

   // Entry one past the table end (sine of pi/2), for a mirrored phase of a full quarter.
   localparam logic [30:0] SINE_PEAK = lfo_sine_entry(LFO_SINE_DEPTH);

   // Configuration registers
   logic [31:0] phase_step_ff;
   logic [31:0] phase_offset_ff;
   logic [1:0]  wave_select_ff;
   logic [15:0] gain_ff;

   // Phase accumulator
   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;

   // Quarter-wave table as constant logic
   logic [30:0] sine_base  [LFO_SINE_DEPTH];
   logic [30:0] sine_delta [LFO_SINE_DEPTH];

   // Pipeline valid bits and stage readiness
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
   logic req_accept;

   // Stage payloads
   logic [31:0]                   s1_phase_ff, s1_phase_in;
   logic [30:0]                   s2_base_ff, s2_base_in;
   logic [30:0]                   s2_delta_ff, s2_delta_in;
   logic [29:0]                   s2_frac_ff, s2_frac_in;
   logic                          s2_neg_ff, s2_neg_in;
   logic                          s2_sine_ff, s2_sine_in;
   logic signed [31:0]            s2_wave_ff, s2_wave_in;
   logic signed [31:0]            s3_value_ff, s3_value_in;
   logic signed [LFO_PROD_W-1:0]  s4_prod_ff, s4_prod_in;
   logic signed [OUT_BITS-1:0]    rsp_sample_ff, rsp_sample_in;

   // Stage 1 helpers
   logic [63:0]           step_wide, offset_wide, phase_wide;
   logic [PHASE_BITS-1:0] phase_sum;

   // Stage 2 helpers
   lfo_wave_type             wave_sel;
   logic [1:0]               quad;
   logic [30:0]              q_mirror;
   logic                     q_full;
   logic [LFO_SINE_LOG-1:0]  tbl_idx;
   logic [31:0]              tri_dist;

   // Stage 3 and 5 helpers
   logic [60:0]                  interp_prod;
   logic [30:0]                  sine_mag;
   logic signed [LFO_PROD_W-1:0] round_sum;
   logic signed [LFO_PROD_W-1:0] round_val;

   for (genvar i = 0; i < LFO_SINE_DEPTH; i++) begin : g_sine_tbl
      assign sine_base[i]  = lfo_sine_entry(i);
      assign sine_delta[i] = lfo_sine_delta(i);
   end

   // A stage may take a new word when it is empty or its word moves on.
   assign s5_ready   = !s5_valid_ff || rsp_ready;
   assign s4_ready   = !s4_valid_ff || s5_ready;
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_ready  = s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign rsp_valid  = s5_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         phase_offset_ff <= '0;
         wave_select_ff  <= WAVE_SINE;
         gain_ff         <= 16'hFFFF;
      end else if (csr_we) begin
         case (lfo_csr_type'(csr_index))
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata;
            CSR_PHASE_OFFSET: phase_offset_ff <= csr_wdata;
            CSR_WAVE_SELECT:  wave_select_ff  <= csr_wdata[1:0];
            CSR_GAIN:         gain_ff         <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Stage 1: phase plus offset, and the accumulator update
   always_comb begin
      step_wide    = (64'(phase_step_ff) << UP_SHIFT) >> DOWN_SHIFT;
      offset_wide  = (64'(phase_offset_ff) << UP_SHIFT) >> DOWN_SHIFT;
      phase_sum    = phase_acc_ff + offset_wide[PHASE_BITS-1:0];
      phase_wide   = (64'(phase_sum) << DOWN_SHIFT) >> UP_SHIFT;
      s1_phase_in  = phase_wide[31:0];
      phase_acc_in = phase_acc_ff;
      if (req_accept && req_advance) begin
         phase_acc_in = phase_acc_ff + step_wide[PHASE_BITS-1:0];
      end
   end

   // Stage 2: waveform shape and sine table lookup
   always_comb begin
      wave_sel = lfo_wave_type'(wave_select_ff);
      quad     = s1_phase_ff[31:30];
      q_mirror = quad[0] ? (31'(LFO_Q30_ONE) - {1'b0, s1_phase_ff[29:0]})
                         : {1'b0, s1_phase_ff[29:0]};
      q_full   = q_mirror[30];
      tbl_idx  = q_mirror[29:FRAC_LOW];
      s2_frac_in  = {q_mirror[FRAC_LOW-1:0], {LFO_SINE_LOG{1'b0}}};
      s2_base_in  = q_full ? SINE_PEAK : sine_base[tbl_idx];
      s2_delta_in = q_full ? 31'd0 : sine_delta[tbl_idx];
      s2_neg_in   = quad[1];
      s2_sine_in  = 1'b0;
      tri_dist    = s1_phase_ff[31] ? {1'b0, s1_phase_ff[30:0]}
                                    : (32'h8000_0000 - s1_phase_ff);
      case (wave_sel)
         WAVE_SQUARE: begin
            s2_wave_in = s1_phase_ff[31] ? LFO_Q30_NEG : LFO_Q30_POS;
         end
         WAVE_TRIANGLE: begin
            s2_wave_in = 32'($signed({1'b0, tri_dist}) - 33'sd1073741824);
         end
         WAVE_SAWTOOTH: begin
            s2_wave_in = 32'($signed({2'b0, s1_phase_ff[31:1]}) - 33'sd1073741824);
         end
         default: begin
            s2_wave_in = '0;
            s2_sine_in = 1'b1;
         end
      endcase
   end

   // Stage 3: linear interpolation and sign of the lower half wave, or the square, triangle or sawtooth value passed on
   always_comb begin
      interp_prod = 61'(s2_delta_ff) * 61'(s2_frac_ff);
      sine_mag    = s2_base_ff + interp_prod[60:30];
      if (s2_sine_ff) begin
         s3_value_in = s2_neg_ff ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
      end else begin
         s3_value_in = s2_wave_ff;
      end
   end

   // Stage 4: gain
   assign s4_prod_in = $signed({{16{s3_value_ff[31]}}, s3_value_ff})
                     * $signed({32'd0, gain_ff});

   // Stage 5: round half up and saturate
   always_comb begin
      round_sum = s4_prod_ff + ROUND_BIAS;
      round_val = round_sum >>> RND_SHIFT;
      if (round_val > SAT_MAX) begin
         rsp_sample_in = SAT_MAX[OUT_BITS-1:0];
      end else if (round_val < SAT_MIN) begin
         rsp_sample_in = SAT_MIN[OUT_BITS-1:0];
      end else begin
         rsp_sample_in = round_val[OUT_BITS-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
      end else begin
         phase_acc_ff <= phase_acc_in;
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_phase_ff <= s1_phase_in;
      end
      if (s2_ready) begin
         s2_base_ff  <= s2_base_in;
         s2_delta_ff <= s2_delta_in;
         s2_frac_ff  <= s2_frac_in;
         s2_neg_ff   <= s2_neg_in;
         s2_sine_ff  <= s2_sine_in;
         s2_wave_ff  <= s2_wave_in;
      end
      if (s3_ready) begin
         s3_value_ff <= s3_value_in;
      end
      if (s4_ready) begin
         s4_prod_ff <= s4_prod_in;
      end
      if (s5_ready) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

endmodule

### sv/lfo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFO port checker
// Watches the ports of the oscillator core for handshake and flow errors.
// ----------------------------------------------------------------------------
module lfo_checker
   import lfo_pkg::*;
#(
   parameter int OUT_BITS = LFO_OUT_BITS
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_sample
);

   // A word offered on the output stays until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("rsp word dropped or changed while stalled");

   // After reset the pipeline is empty and ready for a word.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // The input is only held off when the output is backed up.
   a_ready_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without an output stall");

   // A word taken on the output with none coming in leaves a stage free, so
   // the input is open in the next cycle.
   a_ready_after_take : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !req_valid |=> req_ready)
      else $error("req_ready low just after an output word was taken");

endmodule

bind lfo_multi_waveform_core lfo_checker #(
   .OUT_BITS(OUT_BITS)
) u_lfo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);
